// ===== rtl/core/double_byte_glyph_address_decoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the glyph address decoder
// Shared property wrappers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_BYTE_GLYPH_ADDRESS_DECODER_UNIT_MACROS_SVH
`define DOUBLE_BYTE_GLYPH_ADDRESS_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define DBGAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DBGAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dbgad_pkg.sv =====
// ----------------------------------------------------------------------------
// dbgad_pkg
// Types and constants shared by the glyph address decoder modules.
// ----------------------------------------------------------------------------
package dbgad_pkg;

    localparam int HALF_GLYPH_BYTES = 16;
    localparam int KANJI_BASE       = 4096;
    localparam int KANJI_ROW        = 94;
    localparam int SJIS_ROW_SHIFT   = 62;

    localparam int OFF_W = 20;
    localparam int X_W   = 16;
    localparam int SX_W  = 12;

    localparam logic [7:0] SJIS_LEAD_A_LO = 8'h81;
    localparam logic [7:0] SJIS_LEAD_A_HI = 8'h9f;
    localparam logic [7:0] SJIS_LEAD_B_LO = 8'he0;
    localparam logic [7:0] SJIS_LEAD_B_HI = 8'hfc;
    localparam logic [7:0] SJIS_TRL_A_LO  = 8'h40;
    localparam logic [7:0] SJIS_TRL_A_HI  = 8'h7e;
    localparam logic [7:0] SJIS_TRL_B_LO  = 8'h80;
    localparam logic [7:0] SJIS_TRL_B_HI  = 8'h9e;
    localparam logic [7:0] SJIS_TRL_C_LO  = 8'h9f;
    localparam logic [7:0] EUC_LEAD_LO    = 8'h81;
    localparam logic [7:0] EUC_LEAD_HI    = 8'hfe;
    localparam logic [7:0] EUC_BASE       = 8'ha1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_ASCII = 2'd0,
        MODE_SJIS  = 2'd1,
        MODE_EUC   = 2'd2,
        MODE_OFF   = 2'd3
    } t_mode;

    typedef enum logic {
        KIND_HALF  = 1'b0,
        KIND_KANJI = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               bank;
        logic [OFF_W-1:0]   offset;
        logic [X_W-1:0]     x;
    } t_job;

endpackage

// ===== rtl/core/dbgad_front.sv =====
// ----------------------------------------------------------------------------
// dbgad_front
// Accepts text bytes, tracks column and pending lead byte, and turns each
// single byte or lead/trail pair into a glyph job for the queue, except in the blank mode.
// ----------------------------------------------------------------------------
module dbgad_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_data,
    input  logic                          i_accept,
    input  logic [7:0]                    i_code,
    input  logic                          i_start,
    input  logic [dbgad_pkg::SX_W-1:0]    i_start_x,
    output logic                          o_push,
    output dbgad_pkg::t_job               o_job
);

    dbgad_pkg::t_mode                r_mode;
    logic [7:0]                      r_pending;
    logic [dbgad_pkg::X_W-1:0]       r_column;
    logic [7:0]                      n_pending;
    logic [dbgad_pkg::X_W-1:0]       n_column;

    logic [dbgad_pkg::X_W-1:0]       col_eff;
    logic [dbgad_pkg::OFF_W-1:0]     half_off;
    logic                            sj_lead_a;
    logic                            sj_lead_b;
    logic [10:0]                     k_sj;
    logic [9:0]                      t_sj;
    logic [10:0]                     k_euc;
    logic [9:0]                      t_euc;
    logic [10:0]                     k_sel;
    logic [9:0]                      t_sel;
    logic [dbgad_pkg::OFF_W-1:0]     idx;
    logic [dbgad_pkg::OFF_W-1:0]     kanji_off;
    logic                            push;

    assign col_eff  = i_start ? dbgad_pkg::X_W'(i_start_x) : r_column;
    assign half_off = dbgad_pkg::OFF_W'(i_code)
                    * dbgad_pkg::OFF_W'(dbgad_pkg::HALF_GLYPH_BYTES);

    assign sj_lead_a = (i_code >= dbgad_pkg::SJIS_LEAD_A_LO) &&
                       (i_code <= dbgad_pkg::SJIS_LEAD_A_HI);
    assign sj_lead_b = (i_code >= dbgad_pkg::SJIS_LEAD_B_LO) &&
                       (i_code <= dbgad_pkg::SJIS_LEAD_B_HI);

    // Row and cell indexes, two's complement; out-of-range bytes go negative.
    always_comb begin
        logic [10:0] k_base;
        if ((r_pending >= dbgad_pkg::SJIS_LEAD_A_LO) &&
            (r_pending <= dbgad_pkg::SJIS_LEAD_A_HI)) begin
            k_base = (11'(r_pending) - 11'(dbgad_pkg::SJIS_LEAD_A_LO)) << 1;
        end else begin
            k_base = ((11'(r_pending) - 11'(dbgad_pkg::SJIS_LEAD_B_LO)) << 1)
                   + 11'(dbgad_pkg::SJIS_ROW_SHIFT);
        end
        priority if ((i_code >= dbgad_pkg::SJIS_TRL_A_LO) &&
                     (i_code <= dbgad_pkg::SJIS_TRL_A_HI)) begin
            t_sj = 10'(i_code) - 10'(dbgad_pkg::SJIS_TRL_A_LO);
            k_sj = k_base;
        end else if ((i_code >= dbgad_pkg::SJIS_TRL_B_LO) &&
                     (i_code <= dbgad_pkg::SJIS_TRL_B_HI)) begin
            t_sj = 10'(i_code) - 10'(dbgad_pkg::SJIS_TRL_B_LO) + 10'd63;
            k_sj = k_base;
        end else begin
            t_sj = 10'(i_code) - 10'(dbgad_pkg::SJIS_TRL_C_LO);
            k_sj = k_base + 11'd1;
        end
    end

    assign k_euc = 11'(r_pending) - 11'(dbgad_pkg::EUC_BASE);
    assign t_euc = 10'(i_code) - 10'(dbgad_pkg::EUC_BASE);

    assign k_sel = (r_mode == dbgad_pkg::MODE_EUC) ? k_euc : k_sj;
    assign t_sel = (r_mode == dbgad_pkg::MODE_EUC) ? t_euc : t_sj;

    assign idx = {{(dbgad_pkg::OFF_W-11){k_sel[10]}}, k_sel}
               * dbgad_pkg::OFF_W'(dbgad_pkg::KANJI_ROW)
               + {{(dbgad_pkg::OFF_W-10){t_sel[9]}}, t_sel};
    assign kanji_off = dbgad_pkg::OFF_W'(dbgad_pkg::KANJI_BASE)
                     + idx * dbgad_pkg::OFF_W'(2 * dbgad_pkg::HALF_GLYPH_BYTES);

    always_comb begin
        n_pending   = r_pending;
        push        = 1'b0;
        o_job.kind  = dbgad_pkg::KIND_HALF;
        o_job.bank  = 1'b1;
        o_job.offset = half_off;
        o_job.x     = col_eff;
        unique case (r_mode)
            dbgad_pkg::MODE_ASCII: begin
                push       = 1'b1;
                o_job.bank = 1'b0;
            end
            dbgad_pkg::MODE_SJIS: begin
                if (r_pending == 8'd0) begin
                    if (sj_lead_a || sj_lead_b) begin
                        n_pending = i_code;
                    end else begin
                        push = 1'b1;
                    end
                end else begin
                    push         = 1'b1;
                    n_pending    = 8'd0;
                    o_job.kind   = dbgad_pkg::KIND_KANJI;
                    o_job.offset = kanji_off;
                end
            end
            dbgad_pkg::MODE_EUC: begin
                if (r_pending == 8'd0) begin
                    if ((i_code >= dbgad_pkg::EUC_LEAD_LO) &&
                        (i_code <= dbgad_pkg::EUC_LEAD_HI)) begin
                        n_pending = i_code;
                    end else begin
                        push = 1'b1;
                    end
                end else begin
                    push         = 1'b1;
                    n_pending    = 8'd0;
                    o_job.kind   = dbgad_pkg::KIND_KANJI;
                    o_job.offset = kanji_off;
                end
            end
            dbgad_pkg::MODE_OFF: begin
                n_pending = r_pending;
            end
            default: begin
                n_pending = r_pending;
            end
        endcase
    end

    // Column still loads in the blank mode, but does not advance.
    assign n_column = (r_mode == dbgad_pkg::MODE_OFF) ? col_eff
                                                      : col_eff + dbgad_pkg::X_W'(8);
    assign o_push   = i_accept && push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= dbgad_pkg::MODE_ASCII;
            r_pending <= 8'd0;
            r_column  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= dbgad_pkg::t_mode'(i_cfg_data);
            end
            if (i_accept) begin
                r_pending <= n_pending;
                r_column  <= n_column;
            end
        end
    end

endmodule

// ===== rtl/core/dbgad_queue.sv =====
// ----------------------------------------------------------------------------
// dbgad_queue
// Short FIFO of glyph jobs between the front and back parts.
// ----------------------------------------------------------------------------
`include "double_byte_glyph_address_decoder_unit_macros.svh"

module dbgad_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dbgad_pkg::t_job   i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output dbgad_pkg::t_job   o_job
);

    dbgad_pkg::t_job                  r_mem [dbgad_pkg::QUEUE_DEPTH];
    logic [dbgad_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [dbgad_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [dbgad_pkg::QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (dbgad_pkg::QUEUE_AW+1)'(dbgad_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `DBGAD_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "queue push while full")
    `DBGAD_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "queue pop while empty")

endmodule

// ===== rtl/core/dbgad_back.sv =====
// ----------------------------------------------------------------------------
// dbgad_back
// Pops glyph jobs and drives result beats; a full-width job yields its left
// half then its right half.
// ----------------------------------------------------------------------------
`include "double_byte_glyph_address_decoder_unit_macros.svh"

module dbgad_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  dbgad_pkg::t_job                i_q_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_bank,
    output logic [dbgad_pkg::OFF_W-1:0]    o_offset,
    output logic [dbgad_pkg::X_W-1:0]      o_x,
    output logic                           o_last
);

    logic                           r_valid;
    logic                           r_phase;
    logic                           r_bank;
    logic [dbgad_pkg::OFF_W-1:0]    r_offset;
    logic [dbgad_pkg::X_W-1:0]      r_x;
    logic                           r_last;
    logic                           load;
    logic                           left_half;

    assign load      = !r_valid || i_ready;
    assign left_half = (i_q_job.kind == dbgad_pkg::KIND_KANJI) && !r_phase;
    assign o_pop     = load && i_q_valid && !left_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_phase <= left_half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_bank <= i_q_job.bank;
            if (left_half) begin
                r_offset <= i_q_job.offset;
                r_x      <= i_q_job.x - dbgad_pkg::X_W'(8);
                r_last   <= 1'b0;
            end else if (i_q_job.kind == dbgad_pkg::KIND_KANJI) begin
                r_offset <= i_q_job.offset
                          + dbgad_pkg::OFF_W'(dbgad_pkg::HALF_GLYPH_BYTES);
                r_x      <= i_q_job.x;
                r_last   <= 1'b1;
            end else begin
                r_offset <= i_q_job.offset;
                r_x      <= i_q_job.x;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_bank   = r_bank;
    assign o_offset = r_offset;
    assign o_x      = r_x;
    assign o_last   = r_last;

    `DBGAD_ASSERT_NOW(a_phase_holds_job, i_clk, i_rst_n, r_phase, i_q_valid && r_valid && !r_last, "right half pending without its job")
    `DBGAD_ASSERT_NEXT(a_right_follows_left, i_clk, i_rst_n, r_valid && !r_last && i_ready, r_valid && r_last && r_bank, "left half not followed by right half")
    `DBGAD_ASSERT_NOW(a_left_is_national, i_clk, i_rst_n, r_valid && !r_last, r_bank, "split glyph outside national font")

endmodule

// ===== rtl/core/double_byte_glyph_address_decoder_unit.sv =====
// An accepted byte's glyph job is written into the job queue, then into the back part's output register.
// Throughput: one byte per cycle while the queue is not full; a full-width trail byte gives two beats, so
// the output side sets the sustained rate to one beat per cycle while i_m_tready is high.
// A four-entry job queue between front and back absorbs output stalls.
// Reset (i_rst_n low, synchronous): ASCII mode, column 0, no lead, queue empty.
// ----------------------------------------------------------------------------
// double_byte_glyph_address_decoder_unit
// Text byte stream in, font glyph address and screen column beats out.
// ----------------------------------------------------------------------------
module double_byte_glyph_address_decoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_data,     // language_mode
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [23:0]   i_s_tdata,      // code_byte[7:0], start_x[19:8], zero pad
    input  logic          i_s_tuser,      // string_start
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [39:0]   o_m_tdata,      // glyph_offset[19:0], draw_x[35:20], zero pad
    output logic          o_m_tuser,      // font_bank
    output logic          o_m_tlast       // last
);

    logic                           accept;
    logic                           push;
    logic                           pop;
    logic                           q_full;
    logic                           q_valid;
    dbgad_pkg::t_job                f_job;
    dbgad_pkg::t_job                q_job;
    logic [dbgad_pkg::OFF_W-1:0]    offset;
    logic [dbgad_pkg::X_W-1:0]      draw_x;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !q_full;
    assign accept      = i_s_tvalid && !q_full;

    dbgad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_code      (i_s_tdata[7:0]),
        .i_start     (i_s_tuser),
        .i_start_x   (i_s_tdata[19:8]),
        .o_push      (push),
        .o_job       (f_job)
    );

    dbgad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    dbgad_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_bank    (o_m_tuser),
        .o_offset  (offset),
        .o_x       (draw_x),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {4'b0000, draw_x, offset};

endmodule
